@@ src/sotd_pkg.sv @@
// Shared constants and types of the stuck and off-track detector.
package sotd_pkg;

   localparam int HIST_DEPTH = 64;
   localparam int HIST_AW = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int HIST_CW = $clog2(HIST_DEPTH + 1);

   localparam int TIME_W = 48;
   localparam int POS_W = 25;
   localparam int LAT_W = 21;
   localparam int LIM_W = 20;
   localparam int MOVE_W = 16;
   localparam int CFG_W = 32;
   localparam int CSR_IDX_W = 8;

   localparam int DIFF_W = POS_W + 1;
   localparam int SQ_W = 2 * DIFF_W;
   localparam int M2_W = 2 * MOVE_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_PERIOD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAT_TOL = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_MOVE = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_PERIOD = 8'd5;

   localparam logic [CFG_W-1:0] RST_CHECK_PERIOD = 32'd10000;
   localparam logic [LIM_W-1:0] RST_HALF_WIDTH = 20'd500;
   localparam logic [LIM_W-1:0] RST_LAT_TOL = 20'd100;
   localparam logic [CFG_W-1:0] RST_WINDOW = 32'd2000000;
   localparam logic [MOVE_W-1:0] RST_MIN_MOVE = 16'd100;
   localparam logic [CFG_W-1:0] RST_REPORT_PERIOD = 32'd1000000;

   typedef struct packed {
      logic capture;
      logic push;
      logic rd;
      logic pop;
      logic diff;
      logic sqx;
      logic sqy;
      logic cmp;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic early;
      logic pop_ok;
      logic ref_valid;
      logic suppress;
      logic out_free;
   } status_type;

endpackage

@@ src/sotd_channels.sv @@
// Handshake channel interfaces: sample input, flag result, register write.
interface sotd_req_if import sotd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [TIME_W-1:0]        sample_time_us;
   logic signed [POS_W-1:0]  pos_x_mm;
   logic signed [POS_W-1:0]  pos_y_mm;
   logic signed [LAT_W-1:0]  lateral_error_mm;

   modport source (output valid, sample_time_us, pos_x_mm, pos_y_mm, lateral_error_mm,
                   input ready);
   modport sink (input valid, sample_time_us, pos_x_mm, pos_y_mm, lateral_error_mm,
                 output ready);
endinterface

interface sotd_rsp_if import sotd_pkg::*; ();
   logic valid;
   logic ready;
   logic collision;
   logic off_track;
   logic stuck;

   modport source (output valid, collision, off_track, stuck, input ready);
   modport sink (input valid, collision, off_track, stuck, output ready);
endinterface

interface sotd_csr_if import sotd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/sotd_ctrl.sv @@
// Sequencer for the detector: steps one sample through check, pop loop and report.
module sotd_ctrl import sotd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_CHECK  = 10'b0000000010,
      ST_RD     = 10'b0000000100,
      ST_TEST   = 10'b0000001000,
      ST_DIFF   = 10'b0000010000,
      ST_SQX    = 10'b0000100000,
      ST_SQY    = 10'b0001000000,
      ST_CMP    = 10'b0010000000,
      ST_REPORT = 10'b0100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.early) begin
               state_in = ST_IDLE;
            end else begin
               cmd.push = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.rd = 1'b1;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (status.pop_ok) begin
               cmd.pop = 1'b1;
               state_in = ST_RD;
            end else if (status.ref_valid) begin
               state_in = ST_DIFF;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_SQX;
         end
         ST_SQX: begin
            cmd.sqx = 1'b1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.sqy = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp = 1'b1;
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (status.suppress) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CHECK))
      else $error("accepted item did not move to the check step");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded while output register still full");

endmodule

@@ src/sotd_dp.sv @@
// Detector datapath: registers, history memory, age compares, distance squares, output.
module sotd_dp import sotd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [TIME_W-1:0]        req_time,
   input  logic signed [POS_W-1:0]  req_x,
   input  logic signed [POS_W-1:0]  req_y,
   input  logic signed [LAT_W-1:0]  req_lat,
   input  logic                     csr_write,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]         csr_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic                     rsp_collision,
   output logic                     rsp_off_track,
   output logic                     rsp_stuck
);

   localparam int MEM_W = TIME_W + 2 * POS_W;

   function automatic logic [TIME_W-1:0] age(input logic [TIME_W-1:0] now_t,
                                             input logic [TIME_W-1:0] prev_t);
      return now_t - prev_t;
   endfunction

   function automatic logic [HIST_AW-1:0] wrap_inc(input logic [HIST_AW-1:0] a);
      logic [HIST_AW-1:0] r;
      if (a == HIST_AW'(HIST_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = a + 1'b1;
      end
      return r;
   endfunction

   // configuration
   logic [CFG_W-1:0]  check_period_ff, window_ff, report_period_ff;
   logic [LIM_W-1:0]  half_width_ff, lat_tol_ff;
   logic [MOVE_W-1:0] min_move_ff;

   // sample under work
   logic [TIME_W-1:0]       samp_t_ff;
   logic signed [POS_W-1:0] samp_x_ff, samp_y_ff;
   logic signed [LAT_W-1:0] samp_lat_ff;

   // persistent state
   logic [TIME_W-1:0]  last_sample_ff, last_report_ff;
   logic               reported_ff;
   logic [HIST_AW-1:0] head_ff, head_in;
   logic [HIST_CW-1:0] count_ff, count_in;

   // per-item work registers
   logic                    off_ff, off_in;
   logic                    ref_valid_ff;
   logic signed [POS_W-1:0] ref_x_ff, ref_y_ff;
   logic [MEM_W-1:0]        rd_data_ff;
   logic [DIFF_W-1:0]       dx_ff, dy_ff, dx_in, dy_in;
   logic [M2_W-1:0]         m2_ff;
   logic [SQ_W-1:0]         sqx_ff, sqy_ff;
   logic                    stuck_ff, stuck_in;

   logic                    rsp_valid_ff, rsp_coll_ff, rsp_off_ff, rsp_stuck_ff;

   logic [MEM_W-1:0] mem [HIST_DEPTH];

   logic [HIST_AW-1:0]      slot;
   logic [HIST_CW:0]        slot_sum;
   logic                    full;
   logic [TIME_W-1:0]       rd_time;
   logic signed [POS_W-1:0] rd_x, rd_y;
   logic signed [DIFF_W-1:0] ex_r, ex_p, ey_r, ey_p;
   logic [SQ_W:0]           d2;
   logic                    now_coll;

   assign rd_time = rd_data_ff[MEM_W-1 -: TIME_W];
   assign rd_x    = rd_data_ff[2*POS_W-1 -: POS_W];
   assign rd_y    = rd_data_ff[POS_W-1:0];

   // history push slot
   assign full     = (count_ff >= HIST_CW'(HIST_DEPTH));
   assign slot_sum = (HIST_CW+1)'(head_ff) + (HIST_CW+1)'(count_ff);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (full) begin
         slot = head_ff;
      end else if (slot_sum >= (HIST_CW+1)'(HIST_DEPTH)) begin
         slot = HIST_AW'(slot_sum - (HIST_CW+1)'(HIST_DEPTH));
      end else begin
         slot = HIST_AW'(slot_sum);
      end
      if (cmd.push) begin
         if (full) begin
            head_in = wrap_inc(head_ff);
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else if (cmd.pop) begin
         head_in  = wrap_inc(head_ff);
         count_in = count_ff - 1'b1;
      end
   end

   // negative error never exceeds the nonnegative limit
   assign off_in = $signed({samp_lat_ff[LAT_W-1], samp_lat_ff}) >
                   $signed({2'b00, {1'b0, half_width_ff} + {1'b0, lat_tol_ff}});

   assign ex_r = {ref_x_ff[POS_W-1], ref_x_ff};
   assign ex_p = {samp_x_ff[POS_W-1], samp_x_ff};
   assign ey_r = {ref_y_ff[POS_W-1], ref_y_ff};
   assign ey_p = {samp_y_ff[POS_W-1], samp_y_ff};
   assign dx_in = (ex_r > ex_p) ? $unsigned(ex_r - ex_p) : $unsigned(ex_p - ex_r);
   assign dy_in = (ey_r > ey_p) ? $unsigned(ey_r - ey_p) : $unsigned(ey_p - ey_r);

   assign d2       = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign stuck_in = ref_valid_ff && (d2 < (SQ_W+1)'(m2_ff));
   assign now_coll = off_ff || stuck_ff;

   assign status.early     = age(samp_t_ff, last_sample_ff) < TIME_W'(check_period_ff);
   assign status.pop_ok    = (count_ff != '0) && (age(samp_t_ff, rd_time) >= TIME_W'(window_ff));
   assign status.ref_valid = ref_valid_ff;
   assign status.suppress  = now_coll && reported_ff &&
                             (age(samp_t_ff, last_report_ff) < TIME_W'(report_period_ff));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         check_period_ff  <= RST_CHECK_PERIOD;
         half_width_ff    <= RST_HALF_WIDTH;
         lat_tol_ff       <= RST_LAT_TOL;
         window_ff        <= RST_WINDOW;
         min_move_ff      <= RST_MIN_MOVE;
         report_period_ff <= RST_REPORT_PERIOD;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CHECK_PERIOD:  check_period_ff  <= csr_data;
            CSR_HALF_WIDTH:    half_width_ff    <= csr_data[LIM_W-1:0];
            CSR_LAT_TOL:       lat_tol_ff       <= csr_data[LIM_W-1:0];
            CSR_WINDOW:        window_ff        <= csr_data;
            CSR_MIN_MOVE:      min_move_ff      <= csr_data[MOVE_W-1:0];
            CSR_REPORT_PERIOD: report_period_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff <= '0;
         last_report_ff <= '0;
         reported_ff    <= 1'b0;
         head_ff        <= '0;
         count_ff       <= '0;
         ref_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (cmd.push) begin
            last_sample_ff <= samp_t_ff;
         end
         if (cmd.capture) begin
            ref_valid_ff <= 1'b0;
         end else if (cmd.pop) begin
            ref_valid_ff <= 1'b1;
         end
         if (cmd.emit) begin
            last_report_ff <= samp_t_ff;
            reported_ff    <= now_coll;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         samp_t_ff   <= req_time;
         samp_x_ff   <= req_x;
         samp_y_ff   <= req_y;
         samp_lat_ff <= req_lat;
      end
      if (cmd.push) begin
         off_ff <= off_in;
      end
      if (cmd.pop) begin
         ref_x_ff <= rd_x;
         ref_y_ff <= rd_y;
      end
      if (cmd.diff) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         m2_ff <= M2_W'(min_move_ff) * M2_W'(min_move_ff);
      end
      if (cmd.sqx) begin
         sqx_ff <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
      end
      if (cmd.sqy) begin
         sqy_ff <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
      end
      if (cmd.cmp) begin
         stuck_ff <= stuck_in;
      end
      if (cmd.emit) begin
         rsp_coll_ff  <= now_coll;
         rsp_off_ff   <= off_ff;
         rsp_stuck_ff <= stuck_ff;
      end
   end

   // history memory
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[slot] <= {samp_t_ff, samp_x_ff, samp_y_ff};
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_collision = rsp_coll_ff;
   assign rsp_off_track = rsp_off_ff;
   assign rsp_stuck     = rsp_stuck_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HIST_CW'(HIST_DEPTH))
      else $error("history count above depth");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted result not presented");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (count_ff != '0))
      else $error("pop from empty history");

endmodule

@@ src/stuck_and_off_track_detector.sv @@
// Top level of the stuck and off-track detector.
// Channels: req_ch takes one position sample per item (timestamp, x, y, lateral
// error); rsp_ch returns zero or one flag item (collision, off_track, stuck) per
// sample; csr_ch writes the six configuration registers by index and is always
// ready. Write registers only while no sample is in progress.
// Timing: a sample is taken only while the sequencer is idle. A sample arriving
// before the check period is dropped at the check step. Otherwise the history
// read loop runs once per popped entry plus a final probe; the difference and
// square steps follow only when an entry was popped, then the compare and report
// steps. The single read port of the history memory sets the loop, which reads
// and then tests each entry.
// Reset: configuration registers return to their defaults, the history is
// empty (count zero, no clearing pass) and no result is pending.
// Stall: the result waits in the output register; the next sample can be
// accepted meanwhile and only its own report step waits for the register.
module stuck_and_off_track_detector import sotd_pkg::*; (
   input logic        clock,
   input logic        reset,
   sotd_req_if.sink   req_ch,
   sotd_rsp_if.source rsp_ch,
   sotd_csr_if.sink   csr_ch
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   sotd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sotd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_time      (req_ch.sample_time_us),
      .req_x         (req_ch.pos_x_mm),
      .req_y         (req_ch.pos_y_mm),
      .req_lat       (req_ch.lateral_error_mm),
      .csr_write     (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_collision (rsp_ch.collision),
      .rsp_off_track (rsp_ch.off_track),
      .rsp_stuck     (rsp_ch.stuck)
   );

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

endmodule
